>>> src/kbm_pkg.sv
package kbm_pkg;

    // Sizes fixed by the transaction fields
    localparam int IN_SLOTS     = 6;
    localparam int KEY_W        = 8;
    localparam int BTN_W        = 8;
    localparam int TIME_W       = 32;
    localparam int STRETCH_W    = 24;
    localparam int CFG_DATA_W   = 64;

    // Defaults for the top level parameters
    localparam int BUTTON_COUNT_DEF = 8;
    localparam int KEY_SLOTS_DEF    = 6;

    localparam logic [STRETCH_W-1:0] STRETCH_RESET = 24'd17000;
    localparam logic [BTN_W-1:0]     ALL_RELEASED  = 8'hFF;
    localparam logic [KEY_W-1:0]     ERR_KEY_MAX   = 8'h03;

    // Register indexes
    localparam logic CFG_KEYCODES = 1'b0;
    localparam logic CFG_STRETCH  = 1'b1;

    typedef enum logic [1:0] {
        OP_REPORT     = 2'd0,
        OP_TICK       = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_DISCONNECT = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                            opcode;
        logic [TIME_W-1:0]                  time_us;
        logic [IN_SLOTS-1:0][KEY_W-1:0]     slots;
    } t_in_item;

    typedef struct packed {
        logic [BTN_W-1:0] button_state;
        logic [BTN_W-1:0] raw_button_state;
        logic             state_changed;
        logic             error_report;
        logic [KEY_W-1:0] last_pressed_key;
    } t_out_item;

    // Per-button control from the top level to a stretch lane
    typedef struct packed {
        logic step;      // commit a report or tick this cycle
        logic clear;     // disconnect: back to reset values
        logic report;    // accepted (non-error) report, edges count
        logic raw_prev;  // raw bit before this transaction, active low
        logic raw_next;  // raw bit after this transaction, active low
    } t_lane_ctl;

endpackage

>>> src/kbm_in_if.sv
interface kbm_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [kbm_pkg::TIME_W-1:0] time_us;
    logic [kbm_pkg::KEY_W-1:0]  key_slot_0;
    logic [kbm_pkg::KEY_W-1:0]  key_slot_1;
    logic [kbm_pkg::KEY_W-1:0]  key_slot_2;
    logic [kbm_pkg::KEY_W-1:0]  key_slot_3;
    logic [kbm_pkg::KEY_W-1:0]  key_slot_4;
    logic [kbm_pkg::KEY_W-1:0]  key_slot_5;

    modport source (
        output valid, opcode, time_us,
        output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
        input  ready
    );
    modport sink (
        input  valid, opcode, time_us,
        input  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
        output ready
    );
endinterface

>>> src/kbm_out_if.sv
interface kbm_out_if;
    logic                      valid;
    logic                      ready;
    logic [kbm_pkg::BTN_W-1:0] button_state;
    logic [kbm_pkg::BTN_W-1:0] raw_button_state;
    logic                      state_changed;
    logic                      error_report;
    logic [kbm_pkg::KEY_W-1:0] last_pressed_key;

    modport source (
        output valid, button_state, raw_button_state, state_changed,
        output error_report, last_pressed_key,
        input  ready
    );
    modport sink (
        input  valid, button_state, raw_button_state, state_changed,
        input  error_report, last_pressed_key,
        output ready
    );
endinterface

>>> src/kbm_lane.sv
// Tap stretch for one button: press timestamp, hold deadline, exposed bit.
module kbm_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kbm_pkg::t_lane_ctl                i_ctl,
    input  logic [kbm_pkg::TIME_W-1:0]        i_now,
    input  logic [kbm_pkg::STRETCH_W-1:0]     i_stretch,
    output logic                              o_exposed
);

    logic [kbm_pkg::TIME_W-1:0] r_press_start, n_press_start;
    logic [kbm_pkg::TIME_W-1:0] r_hold, n_hold;
    logic [kbm_pkg::TIME_W-1:0] until_t;
    logic [kbm_pkg::TIME_W-1:0] d_new;
    logic [kbm_pkg::TIME_W-1:0] d_old;
    logic                       new_ok;
    logic                       old_ok;
    logic                       press_edge;
    logic                       rel_edge;

    // wrap-safe "a after b": signed difference strictly positive
    assign until_t = r_press_start + kbm_pkg::TIME_W'(i_stretch);
    assign d_new   = until_t - i_now;
    assign d_old   = r_hold - i_now;
    assign new_ok  = (r_press_start != '0) && (until_t != '0) &&
                     (d_new != '0) && !d_new[kbm_pkg::TIME_W-1];
    assign old_ok  = (r_hold != '0) && (d_old != '0) && !d_old[kbm_pkg::TIME_W-1];

    assign press_edge = i_ctl.report && i_ctl.raw_prev && !i_ctl.raw_next;
    assign rel_edge   = i_ctl.report && !i_ctl.raw_prev && i_ctl.raw_next;

    always_comb begin
        n_press_start = press_edge ? i_now : r_press_start;
        if (!i_ctl.raw_next) begin
            n_hold    = '0;
            o_exposed = 1'b0;
        end else if (rel_edge) begin
            n_hold    = new_ok ? until_t : '0;
            o_exposed = !new_ok;
        end else begin
            n_hold    = old_ok ? r_hold : '0;
            o_exposed = !old_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_press_start <= '0;
            r_hold        <= '0;
        end else if (i_ctl.step) begin
            r_press_start <= n_press_start;
            r_hold        <= n_hold;
        end
    end

endmodule

>>> src/keyboard_report_to_button_mapper.sv
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    opcode, time_us, key_slot_0..key_slot_5
// o_out     out  valid/ready    button_state, raw_button_state, state_changed,
//                               error_report, last_pressed_key
// i_cfg_*   in   write enable   index 0 button_keycodes, 1 tap_stretch_us
//
// One transaction per cycle sustained while the receiver keeps taking
// results; each transaction goes through the input register, then the
// result register.
// All per-transaction work is one pass of parallel keycode compares and one
// 32-bit add/compare per button between the two registers.
// Reset (sync, active low) releases all buttons and restores the stretch to
// 17000 us; keycode bindings reset to zero.
// A stalled output holds its result; the input register still takes a new
// transaction whenever the result register is free or being drained.
module keyboard_report_to_button_mapper #(
    parameter int BUTTON_COUNT = kbm_pkg::BUTTON_COUNT_DEF,  // 1..8
    parameter int KEY_SLOTS    = kbm_pkg::KEY_SLOTS_DEF      // 1..12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    kbm_in_if.sink                            i_in,
    kbm_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [kbm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    // Slots past the six physical fields always read as empty, so they can
    // neither raise an error, match a binding nor be "held" -- drop them.
    localparam int USED_SLOTS = (KEY_SLOTS < kbm_pkg::IN_SLOTS) ? KEY_SLOTS
                                                                : kbm_pkg::IN_SLOTS;

    // ---------------- configuration ----------------
    logic [kbm_pkg::CFG_DATA_W-1:0] r_keycodes;
    logic [kbm_pkg::STRETCH_W-1:0]  r_stretch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keycodes <= '0;
            r_stretch  <= kbm_pkg::STRETCH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kbm_pkg::CFG_KEYCODES: r_keycodes <= i_cfg_wdata;
                kbm_pkg::CFG_STRETCH:  r_stretch  <= i_cfg_wdata[kbm_pkg::STRETCH_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    kbm_pkg::t_in_item r_in;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;

    // Process the held transaction when the result register can take it.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.opcode   <= kbm_pkg::t_opcode'(i_in.opcode);
            r_in.time_us  <= i_in.time_us;
            r_in.slots[0] <= i_in.key_slot_0;
            r_in.slots[1] <= i_in.key_slot_1;
            r_in.slots[2] <= i_in.key_slot_2;
            r_in.slots[3] <= i_in.key_slot_3;
            r_in.slots[4] <= i_in.key_slot_4;
            r_in.slots[5] <= i_in.key_slot_5;
        end
    end

    // ---------------- block state ----------------
    logic [kbm_pkg::BTN_W-1:0]                  r_raw, n_raw;
    logic [kbm_pkg::BTN_W-1:0]                  r_exp, n_exp;
    logic [USED_SLOTS-1:0][kbm_pkg::KEY_W-1:0]  r_prev, n_prev;
    logic [kbm_pkg::KEY_W-1:0]                  r_fnk, n_fnk;

    // ---------------- report decode ----------------
    logic                      err;
    logic [kbm_pkg::BTN_W-1:0] ns;
    logic [kbm_pkg::KEY_W-1:0] new_key;
    logic                      new_found;
    logic [USED_SLOTS-1:0]     held;
    logic                      report_ok;

    always_comb begin
        err = 1'b0;
        for (int k = 0; k < USED_SLOTS; k++) begin
            if ((r_in.slots[k] != '0) && (r_in.slots[k] <= kbm_pkg::ERR_KEY_MAX))
                err = 1'b1;
        end
    end

    // Active-low raw byte: a bound keycode present in any slot presses its
    // button. Empty slots are skipped, so a binding of zero never matches.
    always_comb begin
        ns = kbm_pkg::ALL_RELEASED;
        for (int b = 0; b < BUTTON_COUNT; b++) begin
            for (int k = 0; k < USED_SLOTS; k++) begin
                if ((r_in.slots[k] != '0) &&
                    (r_in.slots[k] == r_keycodes[8*b +: kbm_pkg::KEY_W]))
                    ns[b] = 1'b0;
            end
        end
    end

    // First slot holding a key that was not in the previous report.
    always_comb begin
        new_key   = '0;
        new_found = 1'b0;
        for (int k = 0; k < USED_SLOTS; k++) begin
            held[k] = 1'b0;
            for (int j = 0; j < USED_SLOTS; j++) begin
                if (r_prev[j] == r_in.slots[k])
                    held[k] = 1'b1;
            end
        end
        for (int k = 0; k < USED_SLOTS; k++) begin
            if (!new_found && (r_in.slots[k] != '0) && !held[k]) begin
                new_key   = r_in.slots[k];
                new_found = 1'b1;
            end
        end
    end

    assign report_ok = (r_in.opcode == kbm_pkg::OP_REPORT) && !err;

    // ---------------- stretch lanes ----------------
    logic [kbm_pkg::BTN_W-1:0] lane_exp;
    logic [kbm_pkg::BTN_W-1:0] raw_next;

    assign raw_next = report_ok ? ns : r_raw;

    for (genvar b = 0; b < kbm_pkg::BTN_W; b++) begin : g_btn
        if (b < BUTTON_COUNT) begin : g_lane
            kbm_pkg::t_lane_ctl lane_ctl;

            assign lane_ctl.step     = advance && (report_ok ||
                                       (r_in.opcode == kbm_pkg::OP_TICK));
            assign lane_ctl.clear    = advance && (r_in.opcode == kbm_pkg::OP_DISCONNECT);
            assign lane_ctl.report   = report_ok;
            assign lane_ctl.raw_prev = r_raw[b];
            assign lane_ctl.raw_next = raw_next[b];

            kbm_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (lane_ctl),
                .i_now     (r_in.time_us),
                .i_stretch (r_stretch),
                .o_exposed (lane_exp[b])
            );
        end else begin : g_unused
            // unbuttoned bits stay released
            assign lane_exp[b] = 1'b1;
        end
    end

    // ---------------- next state and result ----------------
    kbm_pkg::t_out_item n_out;
    kbm_pkg::t_out_item r_out;

    always_comb begin
        n_raw  = r_raw;
        n_exp  = r_exp;
        n_prev = r_prev;
        n_fnk  = r_fnk;
        n_out.state_changed = 1'b0;
        n_out.error_report  = 1'b0;
        unique case (r_in.opcode)
            kbm_pkg::OP_REPORT: begin
                if (err) begin
                    // error/rollover report: state untouched, flag only
                    n_out.error_report = 1'b1;
                end else begin
                    n_raw  = ns;
                    n_exp  = lane_exp;
                    n_prev = r_in.slots[USED_SLOTS-1:0];
                    if ((r_fnk == '0) && new_found)
                        n_fnk = new_key;
                    n_out.state_changed = (lane_exp != r_exp);
                end
            end
            kbm_pkg::OP_TICK: begin
                n_exp = lane_exp;
                n_out.state_changed = (lane_exp != r_exp);
            end
            kbm_pkg::OP_CLEAR: begin
                n_fnk = '0;
            end
            kbm_pkg::OP_DISCONNECT: begin
                n_raw  = kbm_pkg::ALL_RELEASED;
                n_exp  = kbm_pkg::ALL_RELEASED;
                n_prev = '0;
                n_fnk  = '0;
                n_out.state_changed = 1'b1;
            end
            default: ;
        endcase
        n_out.button_state     = n_exp;
        n_out.raw_button_state = n_raw;
        n_out.last_pressed_key = n_fnk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= kbm_pkg::ALL_RELEASED;
            r_exp  <= kbm_pkg::ALL_RELEASED;
            r_prev <= '0;
            r_fnk  <= '0;
        end else if (advance) begin
            r_raw  <= n_raw;
            r_exp  <= n_exp;
            r_prev <= n_prev;
            r_fnk  <= n_fnk;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.button_state     = r_out.button_state;
    assign o_out.raw_button_state = r_out.raw_button_state;
    assign o_out.state_changed    = r_out.state_changed;
    assign o_out.error_report     = r_out.error_report;
    assign o_out.last_pressed_key = r_out.last_pressed_key;

endmodule

>>> tb/sv/kbm_result_checker.sv
module kbm_result_checker
    import kbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kbm_in_if                     i_in,
    kbm_out_if                    i_out,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_pending,
    output int                    o_failures
);

    localparam int NBTN = BUTTON_COUNT_DEF;

    // register copies
    logic [CFG_DATA_W-1:0] bindings;
    logic [STRETCH_W-1:0]  stretch_us;

    // mapper state
    logic [BTN_W-1:0]  raw_q;
    logic [BTN_W-1:0]  shown_q;
    logic [TIME_W-1:0] press_at    [BTN_W];
    logic [TIME_W-1:0] stretch_end [BTN_W];
    logic [KEY_W-1:0]  prev_keys   [IN_SLOTS];
    logic [KEY_W-1:0]  first_key;

    t_out_item awaited_states [$];
    t_in_item  seen_in;
    t_out_item got;
    t_out_item want;
    int        failures = 0;

    // a strictly after b, modulo 2^32
    function automatic bit later_than(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[TIME_W-1];
    endfunction

    function automatic void drop_keyboard_state();
        int b;
        int k;
        raw_q     = ALL_RELEASED;
        shown_q   = ALL_RELEASED;
        first_key = '0;
        for (b = 0; b < BTN_W; b++) begin
            press_at[b]    = '0;
            stretch_end[b] = '0;
        end
        for (k = 0; k < IN_SLOTS; k++)
            prev_keys[k] = '0;
    endfunction

    // re-evaluate holds at now; returns 1 when the shown byte moved
    function automatic bit settle_buttons(logic [TIME_W-1:0] now);
        logic [BTN_W-1:0] st;
        int b;
        st = raw_q;
        for (b = 0; b < NBTN; b++) begin
            if (!raw_q[b])
                stretch_end[b] = '0;
            else if (stretch_end[b] != '0 && later_than(stretch_end[b], now))
                st[b] = 1'b0;
            else
                stretch_end[b] = '0;
        end
        if (st == shown_q)
            return 1'b0;
        shown_q = st;
        return 1'b1;
    endfunction

    function automatic t_out_item next_button_state(t_in_item it);
        t_out_item         r;
        logic [BTN_W-1:0]  pressed_n;
        logic [BTN_W-1:0]  before_n;
        logic [KEY_W-1:0]  kc;
        logic [TIME_W-1:0] until_us;
        bit                changed;
        bit                bad;
        bit                held;
        int                k;
        int                j;
        int                b;
        changed = 1'b0;
        bad     = 1'b0;
        case (it.opcode)
            OP_REPORT: begin
                for (k = 0; k < IN_SLOTS; k++)
                    if (it.slots[k] != '0 && it.slots[k] <= ERR_KEY_MAX)
                        bad = 1'b1;
                if (!bad) begin
                    pressed_n = ALL_RELEASED;
                    before_n  = raw_q;
                    for (k = 0; k < IN_SLOTS; k++) begin
                        kc = it.slots[k];
                        if (kc != '0) begin
                            held = 1'b0;
                            for (j = 0; j < IN_SLOTS; j++)
                                if (prev_keys[j] == kc)
                                    held = 1'b1;
                            if (!held && first_key == '0)
                                first_key = kc;
                            for (b = 0; b < NBTN; b++)
                                if (kc == bindings[8*b +: 8])
                                    pressed_n[b] = 1'b0;
                        end
                    end
                    for (k = 0; k < IN_SLOTS; k++)
                        prev_keys[k] = it.slots[k];
                    for (b = 0; b < NBTN; b++) begin
                        if (before_n[b] != pressed_n[b]) begin
                            if (!pressed_n[b]) begin
                                press_at[b]    = it.time_us;
                                stretch_end[b] = '0;
                            end else begin
                                until_us = press_at[b] + TIME_W'(stretch_us);
                                stretch_end[b] = (press_at[b] != '0 &&
                                                  later_than(until_us, it.time_us)) ?
                                                 until_us : '0;
                            end
                        end
                    end
                    raw_q   = pressed_n;
                    changed = settle_buttons(it.time_us);
                end
            end
            OP_TICK:  changed = settle_buttons(it.time_us);
            OP_CLEAR: first_key = '0;
            default: begin
                drop_keyboard_state();
                changed = 1'b1;
            end
        endcase
        r.button_state     = shown_q;
        r.raw_button_state = raw_q;
        r.state_changed    = changed;
        r.error_report     = bad;
        r.last_pressed_key = first_key;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bindings   = '0;
            stretch_us = STRETCH_RESET;
            drop_keyboard_state();
            awaited_states.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_KEYCODES)
                    bindings = i_cfg_wdata;
                else
                    stretch_us = i_cfg_wdata[STRETCH_W-1:0];
            end
            if (i_out.valid && i_out.ready) begin
                got.button_state     = i_out.button_state;
                got.raw_button_state = i_out.raw_button_state;
                got.state_changed    = i_out.state_changed;
                got.error_report     = i_out.error_report;
                got.last_pressed_key = i_out.last_pressed_key;
                if (awaited_states.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: btn %h raw %h chg %b err %b key %h",
                                 got.button_state, got.raw_button_state,
                                 got.state_changed, got.error_report,
                                 got.last_pressed_key);
                end else begin
                    want = awaited_states.pop_front();
                    if (got.button_state !== want.button_state ||
                        got.raw_button_state !== want.raw_button_state ||
                        got.state_changed !== want.state_changed ||
                        got.error_report !== want.error_report ||
                        got.last_pressed_key !== want.last_pressed_key) begin
                        failures++;
                        if (failures <= 10)
                            $display({"mismatch: exp btn %h raw %h chg %b err %b key %h",
                                      " / got btn %h raw %h chg %b err %b key %h"},
                                     want.button_state, want.raw_button_state,
                                     want.state_changed, want.error_report,
                                     want.last_pressed_key,
                                     got.button_state, got.raw_button_state,
                                     got.state_changed, got.error_report,
                                     got.last_pressed_key);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                seen_in.opcode  = t_opcode'(i_in.opcode);
                seen_in.time_us = i_in.time_us;
                seen_in.slots   = {i_in.key_slot_5, i_in.key_slot_4, i_in.key_slot_3,
                                   i_in.key_slot_2, i_in.key_slot_1, i_in.key_slot_0};
                awaited_states.push_back(next_button_state(seen_in));
            end
        end
        o_pending  <= awaited_states.size();
        o_failures <= failures;
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import kbm_pkg::*;

    localparam int STALL_LIMIT     = 5000;  // cycles with no transaction at all
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver back-pressure
    localparam int ITEMS_PER_PHASE = 220;
    localparam int PHASES          = 6;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    pending;
    int                    failures;

    // shared knobs: percent of idle cycles on each side, hold-off trigger
    int idle_pct        = 34;
    bit rx_hold_request = 1'b0;

    // what the stimulus knows of the current setup
    logic [CFG_DATA_W-1:0]          bindings_now = '0;
    logic [STRETCH_W-1:0]           stretch_now  = STRETCH_RESET;
    logic [TIME_W-1:0]              clock_us     = '0;
    logic [IN_SLOTS-1:0][KEY_W-1:0] held_slots   = '0;  // keys currently "down"

    kbm_in_if  in_ch ();
    kbm_out_if out_ch ();

    keyboard_report_to_button_mapper dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    kbm_result_checker result_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    always #4 clk = ~clk;

    // One input transaction. Random idle cycles first, then hold valid until
    // the DUT takes it. valid is left high so back-to-back items keep it up.
    task automatic send_item(input t_opcode op, input logic [TIME_W-1:0] t,
                             input logic [IN_SLOTS-1:0][KEY_W-1:0] s);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.time_us    <= t;
        in_ch.key_slot_0 <= s[0];
        in_ch.key_slot_1 <= s[1];
        in_ch.key_slot_2 <= s[2];
        in_ch.key_slot_3 <= s[3];
        in_ch.key_slot_4 <= s[4];
        in_ch.key_slot_5 <= s[5];
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait for the checker to see every result come back.
    // Each transaction gives exactly one result, so an empty queue means the
    // DUT pipeline is empty too.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Both registers, back to back, only once the block is idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] keys,
                             input logic [CFG_DATA_W-1:0] stretch_word);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KEYCODES;
        cfg_wdata <= keys;
        @(posedge clk);
        cfg_index <= CFG_STRETCH;
        cfg_wdata <= stretch_word;
        @(posedge clk);
        cfg_we       <= 1'b0;
        bindings_now = keys;
        stretch_now  = stretch_word[STRETCH_W-1:0];
    endtask

    // Bindings with some zero (dead) buttons and some duplicated keycodes.
    function automatic logic [CFG_DATA_W-1:0] random_bindings();
        logic [CFG_DATA_W-1:0] v;
        int b;
        v = '0;
        for (b = 0; b < 8; b++) begin
            case ($urandom_range(9))
                0: v[8*b +: 8] = 8'h00;
                1: begin
                    if (b > 0)
                        v[8*b +: 8] = v[8*(b-1) +: 8];
                end
                default: v[8*b +: 8] = 8'($urandom_range(4, 255));
            endcase
        end
        return v;
    endfunction

    // Mostly empty or bound keys, some unbound codes.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        int b;
        r = $urandom_range(99);
        b = $urandom_range(7);
        if (r < 40)
            return '0;
        if (r < 80)
            return bindings_now[8*b +: 8];
        return KEY_W'($urandom_range(4, 255));
    endfunction

    // Small steps keep taps inside the stretch window; occasional long steps
    // and full jumps cover expiry, wrap and the signed-compare half-range.
    function automatic void advance_time();
        case ($urandom_range(19))
            0:       clock_us = $urandom();
            1:       clock_us = clock_us + $urandom_range(0, 33554431);
            2, 3, 4: clock_us = clock_us + $urandom_range(0, 2 * stretch_now + 2);
            default: clock_us = clock_us + $urandom_range(0, 3000);
        endcase
    endfunction

    task automatic send_random_item();
        logic [IN_SLOTS-1:0][KEY_W-1:0] s;
        int r;
        int q;
        int k;
        r = $urandom_range(99);
        if (r < 68) begin
            advance_time();
            s = held_slots;
            q = $urandom_range(99);
            if (q < 45) begin
                // typical keyboard traffic: one key goes down or up
                k = $urandom_range(IN_SLOTS - 1);
                s[k] = pick_key();
                held_slots = s;
            end else if (q < 85) begin
                for (k = 0; k < IN_SLOTS; k++)
                    s[k] = pick_key();
                held_slots = s;
            end else if (q < 93) begin
                // rollover / error code dropped into the current report
                k = $urandom_range(IN_SLOTS - 1);
                s[k] = KEY_W'($urandom_range(1, ERR_KEY_MAX));
            end else begin
                for (k = 0; k < IN_SLOTS; k++)
                    s[k] = KEY_W'($urandom_range(0, 255));
                held_slots = s;
            end
            send_item(OP_REPORT, clock_us, s);
        end else if (r < 88) begin
            advance_time();
            send_item(OP_TICK, clock_us, {$urandom(), 16'($urandom())});
        end else if (r < 95) begin
            send_item(OP_CLEAR, $urandom(), {$urandom(), 16'($urandom())});
        end else begin
            send_item(OP_DISCONNECT, $urandom(), {$urandom(), 16'($urandom())});
            held_slots = '0;
        end
    endtask

    // Receiver: random ready, or a long counted hold-off when requested.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Watchdog: any cycle with a transaction on either channel restarts it.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int n;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_KEYCODES;
        cfg_wdata        <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= OP_REPORT;
        in_ch.time_us    <= '0;
        in_ch.key_slot_0 <= '0;
        in_ch.key_slot_1 <= '0;
        in_ch.key_slot_2 <= '0;
        in_ch.key_slot_3 <= '0;
        in_ch.key_slot_4 <= '0;
        in_ch.key_slot_5 <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset bindings are all zero: a zero binding never matches anything.
        // Slot literals below are slot 5 ... slot 0, left to right.
        send_item(OP_REPORT, 32'd50, 48'h00_00_00_06_05_04);
        send_item(OP_TICK, 32'd60, 48'hFF_FF_FF_FF_FF_FF);

        // button n bound to keycode 4 + n, short stretch for the directed part
        configure(64'h0B0A_0908_0706_0504, 64'd1000);

        // press stamped at time zero reads as never pressed: no stretch
        send_item(OP_REPORT, 32'd0, 48'h00_00_00_00_00_04);
        send_item(OP_REPORT, 32'd10, 48'h0);
        // quick tap on button 0 while button 1 stays down: held to 1100
        send_item(OP_REPORT, 32'd100, 48'h00_00_00_00_05_04);
        send_item(OP_REPORT, 32'd200, 48'h00_00_00_00_00_05);
        send_item(OP_TICK, 32'd500, 48'h0);
        // hold ends exactly at its deadline; tick slots are don't-care
        send_item(OP_TICK, 32'd1100, 48'hFF_FF_FF_FF_FF_FF);
        // error codes 1..3 in any slot: report ignored
        send_item(OP_REPORT, 32'd1200, 48'h00_00_01_00_00_06);
        send_item(OP_REPORT, 32'd1300, 48'hFF_00_00_00_03_00);
        send_item(OP_REPORT, 32'd1400, 48'h02_07_00_00_00_00);
        // unbound codes press no button, so a report of them alone releases button 1
        send_item(OP_REPORT, 32'd1500, 48'hFF_FF_FF_FF_FF_FF);
        send_item(OP_CLEAR, 32'hFFFF_FFFF, 48'hFF_FF_FF_FF_FF_FF);
        send_item(OP_REPORT, 32'd3000, 48'h0B_FF_00_00_00_00);
        // all slots bound, right before the timestamp wraps
        send_item(OP_REPORT, 32'hFFFF_FF00, 48'h09_08_07_06_05_04);
        send_item(OP_REPORT, 32'h0000_0100, 48'h0);
        send_item(OP_TICK, 32'h0000_02E7, 48'h0);
        send_item(OP_TICK, 32'h0000_02E8, 48'h0);
        // half-range jumps exercise the sign of the time difference
        send_item(OP_REPORT, 32'h8000_0000, 48'h00_00_00_00_00_0B);
        send_item(OP_TICK, 32'h0000_0000, 48'h0);
        send_item(OP_REPORT, 32'h8000_0010, 48'h0);
        // disconnect wipes state but keeps the registers
        send_item(OP_DISCONNECT, 32'h1234_5678, 48'hFF_FF_FF_FF_FF_FF);
        send_item(OP_TICK, 32'hFFFF_FFFF, 48'h0);
        send_item(OP_REPORT, 32'hFFFF_FFFF, 48'h0A_0A_0A_0A_0A_0A);
        send_item(OP_CLEAR, 32'd0, 48'h0);

        // Random phases, each with its own register setting.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       configure(64'h0B0A_0908_0706_0504, 64'(STRETCH_RESET));
                1:       configure('1, 64'd0);                  // all on 0xFF, no stretch
                2:       configure(random_bindings(), 64'hFF_FFFF);  // longest stretch
                3:       configure(random_bindings(), 64'($urandom_range(0, 50000)));
                4:       configure('0, {$urandom(), $urandom()});
                default: configure(random_bindings(), {$urandom(), $urandom()});
            endcase
            // phase 2 runs both channels flat out
            idle_pct = (phase == 2) ? 0 : 34;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver stall while we keep pushing: fills the DUT
                if (phase == 3 && n == 60)
                    rx_hold_request = 1'b1;
                // sender pause until everything has come back
                if (phase == 3 && n == 120)
                    drain_results();
                send_random_item();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
